>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif

`endif

>>> rtl/cul_pkg.sv
// ----------------------------------------------------------------------------
// Combination unrank package
// Field widths, register indexes and the command and result beat types.
// ----------------------------------------------------------------------------
package cul_pkg;

   localparam int CFG_W       = 6;
   localparam int RANK_W      = 63;
   localparam int BASE_W      = 10;
   localparam int ELEM_W      = 11;
   localparam int POS_W       = 5;
   localparam int BINOM_W     = 64;
   localparam int CSR_IDX_W   = 1;
   localparam int MAX_N_DEF   = 32;
   localparam int MAX_K_OUT   = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_N_TOTAL  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_CHOSEN = 1'd1;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [BASE_W-1:0] base_offset;
      logic [CFG_W-1:0]  n_total;
      logic [CFG_W-1:0]  k_chosen;
      logic              invalid;
   } cmd_type;

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic [POS_W-1:0]  position;
      logic              last;
      logic              invalid_config;
   } rsp_type;

endpackage

>>> rtl/cul_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cul_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cul_queue.sv
// ----------------------------------------------------------------------------
// Small queue
// Circular buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cul_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cul_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/cul_front.sv
// ----------------------------------------------------------------------------
// Unrank front end
// Holds the n and k registers, takes request beats and tags bad configs.
// ----------------------------------------------------------------------------
module cul_front #(
   parameter int MAX_N = cul_pkg::MAX_N_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cul_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cul_pkg::CFG_W-1:0]      csr_data,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [cul_pkg::RANK_W-1:0]     req_rank,
   input  logic [cul_pkg::BASE_W-1:0]     req_base_offset,
   input  logic                           tbl_ready,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output cul_pkg::cmd_type               cmd_d
);

   import cul_pkg::*;

   logic [CFG_W-1:0] n_ff, n_in;
   logic [CFG_W-1:0] k_ff, k_in;
   logic             bad_cfg;

   assign csr_ready = 1'b1;

   always_comb begin
      n_in = n_ff;
      k_in = k_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_N_TOTAL:  n_in = csr_data;
            CSR_K_CHOSEN: k_in = csr_data;
            default: begin
               n_in = n_ff;
               k_in = k_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= CFG_W'(1);
         k_ff <= CFG_W'(1);
      end else begin
         n_ff <= n_in;
         k_ff <= k_in;
      end
   end

   assign bad_cfg = (n_ff == '0) || (k_ff == '0) || (k_ff > n_ff) ||
                    (n_ff > CFG_W'(MAX_N)) || (k_ff > CFG_W'(MAX_K_OUT));

   assign req_full = cmd_full || !tbl_ready;
   assign cmd_push = req_push && !req_full;

   always_comb begin
      cmd_d.rank        = req_rank;
      cmd_d.base_offset = req_base_offset;
      cmd_d.n_total     = n_ff;
      cmd_d.k_chosen    = k_ff;
      cmd_d.invalid     = bad_cfg;
   end

endmodule

>>> rtl/cul_back.sv
// ----------------------------------------------------------------------------
// Unrank back end
// Builds the binomial table, reduces the rank and scans for each element.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cul_back #(
   parameter int MAX_N = cul_pkg::MAX_N_DEF
) (
   input  logic             clock,
   input  logic             reset,
   output logic             tbl_ready,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  cul_pkg::cmd_type cmd_q,
   input  logic             rsp_full,
   output logic             rsp_push,
   output cul_pkg::rsp_type rsp_d
);

   import cul_pkg::*;

   localparam int W     = $clog2(MAX_N + 1);
   localparam int AW    = 2 * W;
   localparam int DEPTH = 1 << AW;
   localparam int CNT_W = $clog2(RANK_W);

   localparam logic [3:0] ST_FILL_RD  = 4'd0;
   localparam logic [3:0] ST_FILL_WR  = 4'd1;
   localparam logic [3:0] ST_IDLE     = 4'd2;
   localparam logic [3:0] ST_MOD_INIT = 4'd3;
   localparam logic [3:0] ST_MOD      = 4'd4;
   localparam logic [3:0] ST_SCAN_RD  = 4'd5;
   localparam logic [3:0] ST_SCAN_CMP = 4'd6;
   localparam logic [3:0] ST_EMIT     = 4'd7;
   localparam logic [3:0] ST_EMIT_ERR = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [W-1:0]       fm_ff, fm_in;
   logic [W-1:0]       fj_ff, fj_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]       v_ff, v_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BINOM_W-1:0] prev_ff, prev_in;
   logic [BINOM_W-1:0] div_ff, div_in;
   logic [BINOM_W-1:0] rem_ff, rem_in;
   logic [RANK_W-1:0]  dvd_ff, dvd_in;
   cmd_type            cmd_ff, cmd_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [BINOM_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [BINOM_W-1:0] rd_data;

   logic [BINOM_W-1:0] shifted;
   logic [CFG_W-1:0]   scan_m;
   logic [CFG_W-1:0]   scan_j;
   logic               is_last;
   logic               v_in_range;

   cul_ram #(
      .WIDTH (BINOM_W),
      .DEPTH (DEPTH)
   ) u_tbl (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign shifted    = {rem_ff[BINOM_W-2:0], dvd_ff[RANK_W-1]};
   assign scan_m     = cmd_ff.n_total - CFG_W'(v_ff) - CFG_W'(1);
   assign scan_j     = cmd_ff.k_chosen - CFG_W'(pos_ff) - CFG_W'(1);
   assign is_last    = ((CFG_W'(pos_ff) + CFG_W'(1)) == cmd_ff.k_chosen);
   assign v_in_range = (CFG_W'(v_ff) < cmd_ff.n_total);
   assign tbl_ready  = (state_ff != ST_FILL_RD) && (state_ff != ST_FILL_WR);

   always_comb begin
      state_in = state_ff;
      fm_in    = fm_ff;
      fj_in    = fj_ff;
      cnt_in   = cnt_ff;
      v_in     = v_ff;
      pos_in   = pos_ff;
      prev_in  = prev_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      cmd_in   = cmd_ff;
      wr_en    = 1'b0;
      wr_addr  = {fm_ff, fj_ff};
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = {fm_ff - 1'b1, fj_ff};
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_d.element        = ELEM_W'(cmd_ff.base_offset) + ELEM_W'(v_ff);
      rsp_d.position       = pos_ff;
      rsp_d.last           = is_last;
      rsp_d.invalid_config = 1'b0;

      case (state_ff)
         ST_FILL_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FILL_WR;
         end
         ST_FILL_WR: begin
            wr_en = 1'b1;
            if (fm_ff == '0) begin
               wr_data = (fj_ff == '0) ? BINOM_W'(1) : '0;
            end else begin
               wr_data = prev_ff + rd_data;
            end
            if (fj_ff == '1) begin
               prev_in = '0;
               fj_in   = '0;
               if (fm_ff == W'(MAX_N)) begin
                  state_in = ST_IDLE;
               end else begin
                  fm_in    = fm_ff + 1'b1;
                  state_in = ST_FILL_RD;
               end
            end else begin
               prev_in  = rd_data;
               fj_in    = fj_ff + 1'b1;
               state_in = ST_FILL_RD;
            end
         end
         ST_IDLE: begin
            rd_addr = {cmd_q.n_total[W-1:0], cmd_q.k_chosen[W-1:0]};
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = cmd_q;
               state_in = cmd_q.invalid ? ST_EMIT_ERR : ST_MOD_INIT;
            end
         end
         ST_MOD_INIT: begin
            div_in   = rd_data;
            rem_in   = '0;
            dvd_in   = cmd_ff.rank;
            cnt_in   = '0;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            rem_in = (shifted >= div_ff) ? shifted - div_ff : shifted;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RANK_W - 1)) begin
               v_in     = '0;
               pos_in   = '0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            rd_addr = {scan_m[W-1:0], scan_j[W-1:0]};
            if (v_in_range) begin
               rd_en    = 1'b1;
               state_in = ST_SCAN_CMP;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SCAN_CMP: begin
            if (rem_ff < rd_data) begin
               state_in = ST_EMIT;
            end else begin
               rem_in   = rem_ff - rd_data;
               v_in     = v_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               v_in     = v_ff + 1'b1;
               pos_in   = pos_ff + 1'b1;
               state_in = is_last ? ST_IDLE : ST_SCAN_RD;
            end
         end
         ST_EMIT_ERR: begin
            rsp_d.element        = '0;
            rsp_d.position       = '0;
            rsp_d.last           = 1'b1;
            rsp_d.invalid_config = 1'b1;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL_RD;
         fm_ff    <= '0;
         fj_ff    <= '0;
         cnt_ff   <= '0;
         v_ff     <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fm_ff    <= fm_in;
         fj_ff    <= fj_in;
         cnt_ff   <= cnt_in;
         v_ff     <= v_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      cmd_ff  <= cmd_in;
   end

   `ASSERT_PROP(a_rem_below_div, clock, reset, (state_ff == ST_SCAN_RD) |-> (rem_ff < div_ff))
   `ASSERT_PROP(a_emit_in_range, clock, reset, (state_ff == ST_EMIT) |-> v_in_range)
   `ASSERT_PROP(a_last_ends_item, clock, reset, (rsp_push && rsp_d.last) |=> (state_ff == ST_IDLE))
   `ASSERT_NEVER(a_no_push_full, clock, reset, rsp_push && rsp_full)

endmodule

>>> rtl/combination_unrank_lexicographic.sv
// ----------------------------------------------------------------------------
// Lexicographic combination unranking
// Per request, the rank is reduced bit-serially modulo the binomial, then each element
// is found by a table scan; at most n_total - k_chosen candidates are passed over.
// The back end takes a new request only when it is through with the last one;
// the command queue holds waiting requests meanwhile.
// Reset: synchronous; n_total and k_chosen return to 1, then a table build that
// reads and writes each of the (MAX_N+1)*2**clog2(MAX_N+1) entries holds req_full high.
// ----------------------------------------------------------------------------
module combination_unrank_lexicographic #(
   parameter int MAX_N = cul_pkg::MAX_N_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [cul_pkg::RANK_W-1:0]    req_rank,
   input  logic [cul_pkg::BASE_W-1:0]    req_base_offset,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [cul_pkg::ELEM_W-1:0]    rsp_element,
   output logic [cul_pkg::POS_W-1:0]     rsp_position,
   output logic                          rsp_last,
   output logic                          rsp_invalid_config,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cul_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cul_pkg::CFG_W-1:0]     csr_data
);

   import cul_pkg::*;

   logic    tbl_ready;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_d;
   cmd_type cmd_q;
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_d;
   rsp_type rsp_q;

   cul_front #(
      .MAX_N (MAX_N)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_rank        (req_rank),
      .req_base_offset (req_base_offset),
      .tbl_ready       (tbl_ready),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_d           (cmd_d)
   );

   cul_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .full    (cmd_full),
      .wr_data (cmd_d),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .rd_data (cmd_q)
   );

   cul_back #(
      .MAX_N (MAX_N)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tbl_ready (tbl_ready),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_q     (cmd_q),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_d     (rsp_d)
   );

   cul_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_full),
      .wr_data (rsp_d),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_q)
   );

   assign rsp_element        = rsp_q.element;
   assign rsp_position       = rsp_q.position;
   assign rsp_last           = rsp_q.last;
   assign rsp_invalid_config = rsp_q.invalid_config;

endmodule

>>> tb/sv/combination_unrank_lexicographic_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Combination unrank testbench
// Drives rank and base offset beats into the unranker under several n/k
// settings, predicts every subset element from the configured n and k, and
// checks each result beat in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module combination_unrank_lexicographic_test;

   import cul_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int STALL_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [RANK_W-1:0]    req_rank = '0;
   logic [BASE_W-1:0]    req_base_offset = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [ELEM_W-1:0]    rsp_element;
   logic [POS_W-1:0]     rsp_position;
   logic                 rsp_last;
   logic                 rsp_invalid_config;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;

   rsp_type     subset_beats_due[$];
   logic [5:0]  n_total_cfg;
   logic [5:0]  k_chosen_cfg;
   int          mismatch_count = 0;
   int          random_items_sent = 0;
   int unsigned idle_cycles = 0;
   int          pop_mode = 0;
   int          pop_mode_left = 0;

   combination_unrank_lexicographic u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_rank           (req_rank),
      .req_base_offset    (req_base_offset),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_element        (rsp_element),
      .rsp_position       (rsp_position),
      .rsp_last           (rsp_last),
      .rsp_invalid_config (rsp_invalid_config),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   function automatic longint unsigned binomial(input int m, input int j);
      longint unsigned c;
      int i;
      c = 1;
      if (j > m || j < 0) begin
         return 0;
      end
      if (j > m - j) begin
         j = m - j;
      end
      for (i = 0; i < j; i++) begin
         c = c * (m - i) / (i + 1);
      end
      return c;
   endfunction

   function automatic bit config_usable();
      return n_total_cfg != 0 && k_chosen_cfg != 0 && k_chosen_cfg <= n_total_cfg &&
             n_total_cfg <= MAX_N_DEF && k_chosen_cfg <= MAX_K_OUT;
   endfunction

   function automatic void append_due(input rsp_type beat);
      subset_beats_due.insert(subset_beats_due.size(), beat);
   endfunction

   function automatic void predict_subset(input logic [RANK_W-1:0] rank,
                                          input logic [BASE_W-1:0] base);
      rsp_type         beat;
      longint unsigned r;
      int              n;
      int              k;
      int              v;
      int              pos;
      n = int'(n_total_cfg);
      k = int'(k_chosen_cfg);
      beat = '0;
      if (!config_usable()) begin
         beat.last = 1'b1;
         beat.invalid_config = 1'b1;
         append_due(beat);
         return;
      end
      r = {1'b0, rank} % binomial(n, k);
      v = 0;
      for (pos = 0; pos < k; pos++) begin
         while (v < n && r >= binomial(n - v - 1, k - pos - 1)) begin
            r = r - binomial(n - v - 1, k - pos - 1);
            v++;
         end
         beat.element = ELEM_W'(base + v);
         beat.position = POS_W'(pos);
         beat.last = (pos == k - 1);
         beat.invalid_config = 1'b0;
         append_due(beat);
         v++;
      end
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", what);
      end
   endfunction

   // receiver: hold pop on a pattern of its own, switching mode now and then
   always @(negedge clock) begin
      if (pop_mode_left == 0) begin
         pop_mode <= $urandom_range(0, 2);
         pop_mode_left <= $urandom_range(20, 300);
      end else begin
         pop_mode_left <= pop_mode_left - 1;
      end
      case (pop_mode)
         0: begin
            rsp_pop <= 1'b1;
         end
         1: begin
            rsp_pop <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_pop <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      rsp_type due;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (subset_beats_due.size() == 0) begin
            note_mismatch($sformatf("unexpected beat: element %0d position %0d last %0b invalid %0b",
                                    rsp_element, rsp_position, rsp_last, rsp_invalid_config));
         end else begin
            due = subset_beats_due.pop_front();
            if (rsp_element !== due.element || rsp_position !== due.position ||
                rsp_last !== due.last || rsp_invalid_config !== due.invalid_config) begin
               note_mismatch($sformatf({"beat mismatch (n %0d k %0d): expected element %0d ",
                                        "position %0d last %0b invalid %0b, got element %0d ",
                                        "position %0d last %0b invalid %0b"},
                                       n_total_cfg, k_chosen_cfg, due.element, due.position,
                                       due.last, due.invalid_config, rsp_element,
                                       rsp_position, rsp_last, rsp_invalid_config));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(input logic [RANK_W-1:0] rank, input logic [BASE_W-1:0] base);
      @(negedge clock);
      req_push <= 1'b1;
      req_rank <= rank;
      req_base_offset <= base;
      do @(posedge clock); while (req_full);
      predict_subset(rank, base);
   endtask

   task automatic drop_push();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic wait_drained();
      while (subset_beats_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_N_TOTAL) begin
         n_total_cfg = data;
      end else begin
         k_chosen_cfg = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
      drop_push();
      wait_drained();
      if ($urandom_range(0, 1)) begin
         write_csr(CSR_N_TOTAL, n);
         write_csr(CSR_K_CHOSEN, k);
      end else begin
         write_csr(CSR_K_CHOSEN, k);
         write_csr(CSR_N_TOTAL, n);
      end
   endtask

   function automatic logic [RANK_W-1:0] random_rank();
      logic [63:0]     raw;
      longint unsigned c;
      raw = {$urandom(), $urandom()};
      if (!config_usable()) begin
         return raw[RANK_W-1:0];
      end
      c = binomial(int'(n_total_cfg), int'(k_chosen_cfg));
      case ($urandom_range(0, 5))
         0, 1: begin
            return raw[RANK_W-1:0];
         end
         2, 3: begin
            return RANK_W'(raw % c);
         end
         4: begin
            return RANK_W'(c * $urandom_range(1, 1000) - $urandom_range(0, 1));
         end
         default: begin
            return $urandom_range(0, 1) ? '1 : '0;
         end
      endcase
   endfunction

   function automatic logic [BASE_W-1:0] random_base();
      case ($urandom_range(0, 7))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return BASE_W'($urandom_range(0, 1023));
         end
      endcase
   endfunction

   task automatic send_burst(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_item(random_rank(), random_base());
         random_items_sent++;
      end
      drop_push();
      repeat ($urandom_range(1, 20)) @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      send_item('0, '0);
      send_item('1, '1);
      drop_push();
   endtask

   task automatic test_directed_extremes();
      longint unsigned c;
      set_config(32, 32);
      send_item('0, '0);
      send_item('1, '1);
      set_config(32, 16);
      c = binomial(32, 16);
      send_item('0, 10'h155);
      send_item(RANK_W'(c - 1), 10'h2AA);
      send_item(RANK_W'(c), '1);
      send_item('1, '0);
      set_config(32, 1);
      send_item(31, 5);
      send_item('1, 1000);
      set_config(5, 3);
      send_item(0, 7);
      send_item(9, 7);
      send_item(10, 7);
      drop_push();
   endtask

   task automatic test_invalid_configs();
      set_config(4, 9);
      send_item('1, '1);
      set_config(5, 0);
      send_item(3, 100);
      set_config(0, 3);
      send_item(0, 200);
      set_config(63, 3);
      send_item(77, 300);
      set_config(63, 63);
      send_item('1, '0);
      set_config(32, 40);
      send_item(5, 512);
      drop_push();
   endtask

   task automatic test_drain_pause();
      set_config(8, 4);
      send_burst(5);
      wait_drained();
      send_burst(5);
   endtask

   task automatic test_random_traffic();
      int n;
      int k;
      int phase_left;
      int burst;
      while (random_items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 3))
                  0: begin
                     n = 0;
                     k = $urandom_range(0, 63);
                  end
                  1: begin
                     n = $urandom_range(1, 32);
                     k = 0;
                  end
                  2: begin
                     n = $urandom_range(1, 31);
                     k = $urandom_range(n + 1, 63);
                  end
                  default: begin
                     n = $urandom_range(33, 63);
                     k = $urandom_range(0, 63);
                  end
               endcase
            end
            1: begin
               n = 32;
               k = $urandom_range(1, 32);
            end
            2: begin
               n = $urandom_range(1, 32);
               k = $urandom_range(0, 1) ? n : 1;
            end
            default: begin
               n = $urandom_range(1, 12);
               k = $urandom_range(1, n);
            end
         endcase
         set_config(CFG_W'(n), CFG_W'(k));
         phase_left = $urandom_range(15, 45);
         while (phase_left > 0) begin
            burst = $urandom_range(1, 10);
            if (burst > phase_left) begin
               burst = phase_left;
            end
            send_burst(burst);
            phase_left -= burst;
            if ($urandom_range(0, 5) == 0) begin
               wait_drained();
            end
         end
      end
   endtask

   initial begin
      n_total_cfg = 1;
      k_chosen_cfg = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_extremes();
      test_invalid_configs();
      test_drain_pause();
      test_random_traffic();
      drop_push();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/cul_pkg.sv
rtl/cul_ram.sv
rtl/cul_queue.sv
rtl/cul_front.sv
rtl/cul_back.sv
rtl/combination_unrank_lexicographic.sv
tb/sv/combination_unrank_lexicographic_test.sv
